FILE: src/msv_pkg.sv
`timescale 1ns / 1ps
// Shared widths and the transaction type passed from the front end to the accumulator.
package msv_pkg;

    // Coordinate width of one vertex component.
    localparam int COORD_W = 16;
    // Width of one cross-product term (16 x 16 signed).
    localparam int MUL_W = 2 * COORD_W;
    // Width of one cross-product component (difference of two terms).
    localparam int CROSS_W = MUL_W + 1;
    // Width of one partial dot-product term.
    localparam int TERM_W = COORD_W + CROSS_W;
    // Width of the full triple product; its magnitude stays below 2^51.
    localparam int PROD_W = 52;
    // Width of the running sum.
    localparam int SUM_W = 64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // One classified triangle waiting for the accumulator.
    typedef struct packed {
        logic signed [PROD_W-1:0] triple;
        logic                     first;
        logic                     last;
    } msv_item_t;

endpackage

FILE: src/msv_tri_if.sv
`timescale 1ns / 1ps
// Triangle input channel: three signed vertices and the mesh framing flags.
interface msv_tri_if;
    import msv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      first_triangle;
    logic                      last_triangle;

    modport source (
        output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
               first_triangle, last_triangle,
        input  ready
    );

    modport sink (
        input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
               first_triangle, last_triangle,
        output ready
    );
endinterface

FILE: src/msv_sum_if.sv
`timescale 1ns / 1ps
// Result channel: running six-times-volume sum with clip and done flags.
interface msv_sum_if;
    import msv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] six_volume_sum;
    logic                    saturated;
    logic                    mesh_done;

    modport source (
        output valid, six_volume_sum, saturated, mesh_done,
        input  ready
    );

    modport sink (
        input  valid, six_volume_sum, saturated, mesh_done,
        output ready
    );
endinterface

FILE: src/mesh_signed_volume.sv
`timescale 1ns / 1ps
// Top level of the signed mesh volume accumulator.
//
// Usage: each transaction on the triangle channel carries one mesh triangle as
// three signed 16-bit vertices plus the first_triangle and last_triangle flags.
// For every triangle exactly one transaction leaves on the result channel with
// the running sum of triple products a . (b x c), which is six times the signed
// mesh volume; software divides by six. The sum saturates at the 64-bit limits
// and the saturated flag then stays set until a triangle with first_triangle.
// mesh_done echoes last_triangle, marking the sum as final for that mesh.
// Path: an accepted triangle passes the front-end pipeline stages, is written
// into the queue and then updates the accumulator, whose registers hold the result.
// Throughput: one triangle per cycle while the receiver takes every result; the
// saturating add of the accumulator is the only serial step.
// Reset clears the accumulator, the saturation flag, the pipeline and the queue.
// When the receiver stalls, the result is held in the output register, the queue
// fills, and then the front-end pipeline halts and drops triangle.ready.
module mesh_signed_volume #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    msv_tri_if.sink   triangle,
    msv_sum_if.source result
);
    import msv_pkg::*;

    logic      push_valid;
    logic      push_ready;
    msv_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    msv_item_t pop_item;

    // Front end: multiplier pipeline producing the triple product.
    msv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .triangle   (triangle),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // Decoupling queue so the accumulator and the pipeline stall independently.
    msv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // Back end: saturating accumulator and result register.
    msv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .result    (result)
    );

    // A triple product blocked at the queue input must still be offered next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready |=> push_valid)
    else $error("front end dropped a pending triple product");

    // Every item taken from the queue shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> result.valid)
    else $error("queue item taken without a result");

    // A result never appears without an item having been taken from the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(pop_valid && pop_ready))
    else $error("result appeared without a queue item");

endmodule

FILE: src/msv_front.sv
`timescale 1ns / 1ps
// Front end: three-stage pipeline that turns a triangle into its triple product.
module msv_front (
    input  logic              clk,
    input  logic              rst_n,
    msv_tri_if.sink           triangle,
    output logic              push_valid,
    output msv_pkg::msv_item_t push_item,
    input  logic              push_ready
);
    import msv_pkg::*;

    logic advance;

    // Stage 1: the six cross-product terms.
    logic                      s1_valid_reg;
    logic signed [MUL_W-1:0]   m_bycz_reg, m_bzcy_reg, m_bzcx_reg;
    logic signed [MUL_W-1:0]   m_bxcz_reg, m_bxcy_reg, m_bycx_reg;
    logic signed [MUL_W-1:0]   m_bycz_next, m_bzcy_next, m_bzcx_next;
    logic signed [MUL_W-1:0]   m_bxcz_next, m_bxcy_next, m_bycx_next;
    logic signed [COORD_W-1:0] s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic                      s1_first_reg, s1_last_reg;

    // Stage 2: the cross product b x c.
    logic                      s2_valid_reg;
    logic signed [CROSS_W-1:0] kx_reg, ky_reg, kz_reg;
    logic signed [CROSS_W-1:0] kx_next, ky_next, kz_next;
    logic signed [COORD_W-1:0] s2_ax_reg, s2_ay_reg, s2_az_reg;
    logic                      s2_first_reg, s2_last_reg;

    // Stage 3: the three dot-product terms.
    logic                      s3_valid_reg;
    logic signed [TERM_W-1:0]  tx_reg, ty_reg, tz_reg;
    logic signed [TERM_W-1:0]  tx_next, ty_next, tz_next;
    logic                      s3_first_reg, s3_last_reg;

    // The whole pipeline moves together; it only stops when its last stage is blocked.
    assign advance        = !s3_valid_reg || push_ready;
    assign triangle.ready = advance;

    assign m_bycz_next = triangle.by_coord * triangle.cz;
    assign m_bzcy_next = triangle.bz * triangle.cy;
    assign m_bzcx_next = triangle.bz * triangle.cx;
    assign m_bxcz_next = triangle.bx * triangle.cz;
    assign m_bxcy_next = triangle.bx * triangle.cy;
    assign m_bycx_next = triangle.by_coord * triangle.cx;

    assign kx_next = {m_bycz_reg[MUL_W-1], m_bycz_reg} - {m_bzcy_reg[MUL_W-1], m_bzcy_reg};
    assign ky_next = {m_bzcx_reg[MUL_W-1], m_bzcx_reg} - {m_bxcz_reg[MUL_W-1], m_bxcz_reg};
    assign kz_next = {m_bxcy_reg[MUL_W-1], m_bxcy_reg} - {m_bycx_reg[MUL_W-1], m_bycx_reg};

    assign tx_next = s2_ax_reg * kx_reg;
    assign ty_next = s2_ay_reg * ky_reg;
    assign tz_next = s2_az_reg * kz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= triangle.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_bycz_reg   <= m_bycz_next;
            m_bzcy_reg   <= m_bzcy_next;
            m_bzcx_reg   <= m_bzcx_next;
            m_bxcz_reg   <= m_bxcz_next;
            m_bxcy_reg   <= m_bxcy_next;
            m_bycx_reg   <= m_bycx_next;
            s1_ax_reg    <= triangle.ax;
            s1_ay_reg    <= triangle.ay;
            s1_az_reg    <= triangle.az;
            s1_first_reg <= triangle.first_triangle;
            s1_last_reg  <= triangle.last_triangle;

            kx_reg       <= kx_next;
            ky_reg       <= ky_next;
            kz_reg       <= kz_next;
            s2_ax_reg    <= s1_ax_reg;
            s2_ay_reg    <= s1_ay_reg;
            s2_az_reg    <= s1_az_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;

            tx_reg       <= tx_next;
            ty_reg       <= ty_next;
            tz_reg       <= tz_next;
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // The final three-way add feeds the queue directly.
    always_comb
    begin
        push_item.triple = PROD_W'(tx_reg) + PROD_W'(ty_reg) + PROD_W'(tz_reg);
        push_item.first  = s3_first_reg;
        push_item.last   = s3_last_reg;
    end

    assign push_valid = s3_valid_reg;

endmodule

FILE: src/msv_queue.sv
`timescale 1ns / 1ps
// Small first-in first-out queue between the front end and the accumulator.
module msv_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  msv_pkg::msv_item_t push_item,
    output logic               push_ready,
    output logic               pop_valid,
    output msv_pkg::msv_item_t pop_item,
    input  logic               pop_ready
);
    import msv_pkg::*;

    // DEPTH must be a power of two so that the pointers wrap naturally.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    msv_item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/msv_back.sv
`timescale 1ns / 1ps
// Back end: saturating 64-bit accumulator whose registers also form the result register.
module msv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    input  msv_pkg::msv_item_t pop_item,
    output logic               pop_ready,
    msv_sum_if.source          result
);
    import msv_pkg::*;

    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic                    clip_reg, clip_next;
    logic                    done_reg;
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W:0]   sum_wide;
    logic                    ovf_pos, ovf_neg;
    logic                    take;

    // A new triangle is taken once the previous result has left.
    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        base     = pop_item.first ? '0 : acc_reg;
        sum_wide = {base[SUM_W-1], base} + (SUM_W + 1)'(pop_item.triple);
        ovf_pos  = !sum_wide[SUM_W] && sum_wide[SUM_W-1];
        ovf_neg  = sum_wide[SUM_W] && !sum_wide[SUM_W-1];
        if (ovf_pos)
        begin
            acc_next = SUM_MAX;
        end
        else if (ovf_neg)
        begin
            acc_next = SUM_MIN;
        end
        else
        begin
            acc_next = sum_wide[SUM_W-1:0];
        end
        clip_next = (clip_reg && !pop_item.first) || ovf_pos || ovf_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_reg  <= acc_next;
                clip_reg <= clip_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            done_reg <= pop_item.last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.six_volume_sum = acc_reg;
    assign result.saturated      = clip_reg;
    assign result.mesh_done      = done_reg;

endmodule
